// ===== rtl/pbm_pkg.sv =====
// Shared types and constants for the binary PBM (P4) stream decoder.
// No dependencies; imported by the parser, the pixel unpacker and the top level.
`default_nettype none

package pbm_pkg;

  // Header characters.
  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_FOUR    = 8'h34;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  localparam logic [7:0] PIX_CLEAR = 8'd255;
  localparam logic [7:0] PIX_SET   = 8'd0;

  // Error codes carried by an error result.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ERR_BAD_SEP   = 3'd2;
  localparam logic [2:0] ERR_BAD_DIGIT = 3'd3;
  localparam logic [2:0] ERR_BAD_DIM   = 3'd4;

  localparam int OUT_DATA_W = 40;

  // One unit of work handed from the parser to the unpacker: either a single
  // error result or one raster byte that expands to cnt_m1+1 pixels.
  typedef struct packed {
    logic        is_err;
    logic [2:0]  err_code;
    logic [7:0]  bits;
    logic [11:0] row;
    logic [11:0] col_base;
    logic [2:0]  cnt_m1;
    logic        last_img;
  } pbm_job_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pbm_parser.sv =====
// Header parser and raster position tracker for the PBM (P4) decoder.
// Depends on pbm_pkg; turns each accepted beat into at most one job for pbm_unpack.
`default_nettype none

module pbm_parser
  import pbm_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       start_of_file,
  output logic            job_push,
  output pbm_job_t        job
);

  localparam int DIM_W   = $clog2(MAX_DIM + 2);
  localparam int BIR_W   = $clog2((MAX_DIM + 7) / 8 + 1);
  localparam int ACC_W   = DIM_W + 4;
  localparam int COL_W   = DIM_W + 1;
  localparam logic [DIM_W-1:0] MAX_V = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] SAT_V = DIM_W'(MAX_DIM + 1);

  typedef enum logic [11:0] {
    PH_MAGIC         = 12'b0000_0000_0001,
    PH_GOT_P         = 12'b0000_0000_0010,
    PH_AFTER_MAGIC   = 12'b0000_0000_0100,
    PH_COMMENT_CHECK = 12'b0000_0000_1000,
    PH_IN_COMMENT    = 12'b0000_0001_0000,
    PH_WIDTH_LEAD    = 12'b0000_0010_0000,
    PH_WIDTH_DIGITS  = 12'b0000_0100_0000,
    PH_HEIGHT_LEAD   = 12'b0000_1000_0000,
    PH_HEIGHT_DIGITS = 12'b0001_0000_0000,
    PH_RASTER        = 12'b0010_0000_0000,
    PH_ERROR         = 12'b0100_0000_0000,
    PH_DONE          = 12'b1000_0000_0000
  } phase_t;

  phase_t             phase, phase_next, ph;
  logic [DIM_W-1:0]   acc, acc_next;
  logic [DIM_W-1:0]   image_width, image_width_next;
  logic [DIM_W-1:0]   image_height, image_height_next;
  logic [BIR_W-1:0]   bpr, bpr_next;
  logic [DIM_W-1:0]   row_counter, row_counter_next;
  logic [BIR_W-1:0]   byte_in_row, byte_in_row_next;

  logic               sp, dig, err_push, pix_push;
  logic [2:0]         err_code;
  logic [DIM_W-1:0]   acc_first, acc_more;
  logic               acc_bad;
  logic [COL_W-1:0]   col_base, remain;
  logic [2:0]         cnt_m1;
  logic               row_end, img_end;
  logic [DIM_W-1:0]   row_inc;
  logic [DIM_W:0]     width_round;

  // Decimal accumulate with saturation just above the largest legal size.
  function automatic logic [DIM_W-1:0] accumulate(input logic [DIM_W-1:0] base,
                                                   input logic [7:0] b);
    logic [ACC_W-1:0] sum;
    sum = ACC_W'(base) * ACC_W'(10) + ACC_W'(b - CH_ZERO);
    return (sum > ACC_W'(MAX_DIM)) ? SAT_V : sum[DIM_W-1:0];
  endfunction

  always_comb begin
    ph        = start_of_file ? PH_MAGIC : phase;
    sp        = is_space(data_byte);
    dig       = is_digit(data_byte);
    acc_first = accumulate('0, data_byte);
    acc_more  = accumulate(acc, data_byte);
    acc_bad   = (acc == '0) || (acc > MAX_V);

    col_base = COL_W'({byte_in_row, 3'b000});
    remain   = COL_W'(image_width) - col_base;
    cnt_m1   = (remain >= COL_W'(8)) ? 3'd7 : 3'(remain[2:0] - 3'd1);
    row_end  = (byte_in_row + BIR_W'(1)) == bpr;
    row_inc  = row_counter + DIM_W'(1);
    img_end  = row_end && (row_inc == image_height);
    width_round = (DIM_W + 1)'(acc) + (DIM_W + 1)'(7);

    phase_next        = phase;
    acc_next          = acc;
    image_width_next  = image_width;
    image_height_next = image_height;
    bpr_next          = bpr;
    row_counter_next  = row_counter;
    byte_in_row_next  = byte_in_row;
    err_push          = 1'b0;
    err_code          = ERR_NONE;
    pix_push          = 1'b0;

    case (ph)
      PH_MAGIC: begin
        if (data_byte == CH_P) begin
          phase_next = PH_GOT_P;
        end else if (!sp) begin
          err_push = 1'b1;
          err_code = ERR_BAD_MAGIC;
        end else begin
          phase_next = PH_MAGIC;
        end
      end
      PH_GOT_P: begin
        if (data_byte == CH_FOUR) begin
          phase_next = PH_AFTER_MAGIC;
        end else begin
          err_push = 1'b1;
          err_code = ERR_BAD_MAGIC;
        end
      end
      PH_AFTER_MAGIC: begin
        if (data_byte == CH_NEWLINE) begin
          phase_next = PH_COMMENT_CHECK;
        end else begin
          err_push = 1'b1;
          err_code = sp ? ERR_BAD_SEP : ERR_BAD_MAGIC;
        end
      end
      PH_COMMENT_CHECK, PH_WIDTH_LEAD: begin
        // A byte that does not open a comment already belongs to the width.
        if ((ph == PH_COMMENT_CHECK) && (data_byte == CH_HASH)) begin
          phase_next = PH_IN_COMMENT;
        end else if (sp) begin
          phase_next = PH_WIDTH_LEAD;
        end else if (dig) begin
          acc_next   = acc_first;
          phase_next = PH_WIDTH_DIGITS;
        end else begin
          err_push = 1'b1;
          err_code = ERR_BAD_DIGIT;
        end
      end
      PH_IN_COMMENT: begin
        if (data_byte == CH_NEWLINE) begin
          phase_next = PH_WIDTH_LEAD;
        end
      end
      PH_WIDTH_DIGITS: begin
        if (dig) begin
          acc_next = acc_more;
        end else if (data_byte != CH_SPACE) begin
          err_push = 1'b1;
          err_code = ERR_BAD_SEP;
        end else if (acc_bad) begin
          err_push = 1'b1;
          err_code = ERR_BAD_DIM;
        end else begin
          image_width_next = acc;
          bpr_next         = BIR_W'(width_round >> 3);
          acc_next         = '0;
          phase_next       = PH_HEIGHT_LEAD;
        end
      end
      PH_HEIGHT_LEAD: begin
        if (sp) begin
          phase_next = PH_HEIGHT_LEAD;
        end else if (dig) begin
          acc_next   = acc_first;
          phase_next = PH_HEIGHT_DIGITS;
        end else begin
          err_push = 1'b1;
          err_code = ERR_BAD_DIGIT;
        end
      end
      PH_HEIGHT_DIGITS: begin
        if (dig) begin
          acc_next = acc_more;
        end else if (data_byte != CH_NEWLINE) begin
          err_push = 1'b1;
          err_code = ERR_BAD_SEP;
        end else if (acc_bad) begin
          err_push = 1'b1;
          err_code = ERR_BAD_DIM;
        end else begin
          image_height_next = acc;
          acc_next          = '0;
          row_counter_next  = '0;
          byte_in_row_next  = '0;
          phase_next        = PH_RASTER;
        end
      end
      PH_RASTER: begin
        pix_push = 1'b1;
        if (row_end) begin
          byte_in_row_next = '0;
          row_counter_next = row_inc;
          if (row_inc == image_height) begin
            phase_next = PH_DONE;
          end
        end else begin
          byte_in_row_next = byte_in_row + BIR_W'(1);
        end
      end
      PH_ERROR, PH_DONE: begin
        phase_next = ph;
      end
      default: begin
        phase_next = PH_MAGIC;
      end
    endcase

    if (err_push) begin
      phase_next = PH_ERROR;
    end

    job_push     = accept && (err_push || pix_push);
    job          = '0;
    job.is_err   = err_push;
    job.err_code = err_code;
    if (pix_push) begin
      job.bits     = data_byte;
      job.row      = 12'(row_counter);
      job.col_base = 12'(col_base);
      job.cnt_m1   = cnt_m1;
      job.last_img = img_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc          <= acc_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      bpr          <= bpr_next;
      row_counter  <= row_counter_next;
      byte_in_row  <= byte_in_row_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pbm_unpack.sv =====
// Pixel unpacker: holds one job and expands it into result beats, one per cycle unless m_tready stalls.
// Depends on pbm_pkg; drives the registered master-side stream of the decoder.
`default_nettype none

module pbm_unpack
  import pbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  job_push,
  input  wire pbm_job_t              job_in,
  output logic                       job_ready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // pixel_value, pixel_row, pixel_col, error_code
  output logic                       m_tuser,   // kind
  output logic                       m_tlast    // last_pixel
);

  pbm_job_t   job;
  logic       job_valid;
  logic [2:0] idx;

  logic       out_load, step_last, job_done;
  logic [7:0] pix_value;
  logic [11:0] pix_col;
  logic       pix_last;

  assign out_load  = !m_tvalid || m_tready;
  assign step_last = job.is_err || (idx == job.cnt_m1);
  assign job_done  = job_valid && out_load && step_last;
  assign job_ready = !job_valid || job_done;

  always_comb begin
    pix_value = job.bits[3'd7 - idx] ? PIX_SET : PIX_CLEAR;
    pix_col   = job.col_base + 12'(idx);
    pix_last  = job.last_img && (idx == job.cnt_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (job_push) begin
      job_valid <= 1'b1;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) begin
      job <= job_in;
      idx <= '0;
    end else if (job_valid && out_load) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && job_valid) begin
      m_tuser <= job.is_err;
      if (job.is_err) begin
        m_tdata <= {5'd0, job.err_code, 12'd0, 12'd0, 8'd0};
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= {5'd0, ERR_NONE, pix_col, job.row, pix_value};
        m_tlast <= pix_last;
      end
    end
  end

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    job_push |-> job_ready)
    else $error("job pushed while the unpacker is still busy");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job.is_err) |-> (idx <= job.cnt_m1))
    else $error("pixel index ran past the end of its byte");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !m_tuser)
    else $error("last-pixel flag on an error beat");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.is_err && out_load && !job_push) |=> !job_valid)
    else $error("error job produced more than one beat");

endmodule

`default_nettype wire

// ===== rtl/pbm_p4_stream_decoder.sv =====
// Top level of the binary PBM (P4) stream decoder.
// Depends on pbm_pkg, pbm_parser and pbm_unpack.
//
//  Port group   Dir   Beat contents (low bits first)
//  s_*          in    tdata: data_byte[7:0]; tuser: start_of_file
//  m_*          out   tdata: pixel_value[7:0], pixel_row[19:8], pixel_col[31:20],
//                     error_code[34:32], zero[39:35]; tuser: kind; tlast: last_pixel
//
// A header byte is parsed in the cycle it is accepted and yields no beat or one
// error beat. A raster byte yields one to eight pixel beats, one per cycle unless
// m_tready stalls; the next byte waits while the unpacker still holds its job.
// The next input beat is taken in the cycle the unpacker issues its last beat.
// Reset puts the parser at the start of a file; the output stalls freely on m_tready.
`default_nettype none

module pbm_p4_stream_decoder
  import pbm_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // data_byte
  input  wire logic                  s_tuser,   // start_of_file
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // pixel_value, pixel_row, pixel_col, error_code
  output logic                       m_tuser,   // kind
  output logic                       m_tlast    // last_pixel
);

  logic     accept;
  logic     job_push;
  logic     job_ready;
  pbm_job_t job;

  assign s_tready = job_ready;
  assign accept   = s_tvalid && job_ready;

  pbm_parser #(
    .MAX_DIM(MAX_DIM)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (s_tdata),
    .start_of_file (s_tuser),
    .job_push      (job_push),
    .job           (job)
  );

  pbm_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .job_push  (job_push),
    .job_in    (job),
    .job_ready (job_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/pbm_p4_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pbm_p4_stream_decoder: a short table of directed header and
// raster beats, then random PBM files, checked beat by beat against a behavioral decoder
// or a hand-set expectation. Depends on pbm_pkg and the decoder RTL; needs no files or arguments.

module pbm_p4_stream_decoder_test;
  import pbm_pkg::*;

  localparam int MAX_DIM      = 4096;
  localparam int RANDOM_ITEMS = 232;
  localparam int HOLD_CYCLES  = 400;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
    logic [2:0]  code;
  } out_beat_t;

  // One input beat; a hand-checked beat carries its own expectation instead of the decoder's.
  typedef struct packed {
    logic      [7:0] data;
    logic            sof;
    logic            hand_checked;
    logic            has_beat;
    out_beat_t       beat;
  } in_beat_t;

  typedef enum logic [3:0] {
    HDR_MAGIC, HDR_GOT_P, HDR_AFTER_MAGIC, HDR_COMMENT_CHECK, HDR_IN_COMMENT,
    HDR_WIDTH_LEAD, HDR_WIDTH_DIGITS, HDR_HEIGHT_LEAD, HDR_HEIGHT_DIGITS,
    HDR_RASTER, HDR_ERROR, HDR_DONE
  } hdr_phase_t;

  typedef enum int {
    FILE_CLEAN, FILE_BAD_MAGIC, FILE_BAD_AFTER_MAGIC, FILE_SECOND_COMMENT,
    FILE_BAD_WIDTH_START, FILE_BAD_WIDTH_DIM, FILE_BAD_WIDTH_END, FILE_BAD_HEIGHT_DIM,
    FILE_BAD_HEIGHT_END, FILE_MAX_TRUNCATED, FILE_NOISE
  } file_flaw_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_THREE_OF_FOUR, RX_SPARSE} rx_mode_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  pbm_p4_stream_decoder #(.MAX_DIM(MAX_DIM)) dut (.*);

  // Behavioral decoder state.
  hdr_phase_t  phase = HDR_MAGIC;
  logic [12:0] img_w = '0, img_h = '0, acc = '0, row_idx = '0;
  logic [9:0]  byte_idx = '0;

  out_beat_t fresh_beats[$];
  out_beat_t expected_beats[$];
  logic [7:0] file_bytes[$];
  in_beat_t  cur_item = '0;
  int        mismatches = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  logic      hold_req = 1'b0, hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic blank_char(logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic void flag_error(logic [2:0] code);
    out_beat_t e;
    e = '0;
    e.kind = KIND_ERROR;
    e.code = code;
    phase = HDR_ERROR;
    fresh_beats = {fresh_beats, e};
  endfunction

  // The accumulator saturates one above the largest legal dimension.
  function automatic void add_digit(logic [7:0] c);
    int v;
    v = acc * 10 + (c - CH_ZERO);
    if (v > MAX_DIM) v = MAX_DIM + 1;
    acc = 13'(v);
  endfunction

  function automatic void start_number(logic [7:0] c, hdr_phase_t digits_phase);
    if (!blank_char(c)) begin
      if (!digit_char(c)) begin
        flag_error(ERR_BAD_DIGIT);
      end else begin
        acc = '0;
        add_digit(c);
        phase = digits_phase;
      end
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sof);
    int col;
    out_beat_t px;
    if (sof) begin
      phase = HDR_MAGIC;
      img_w = '0;
      img_h = '0;
      acc = '0;
      row_idx = '0;
      byte_idx = '0;
    end
    case (phase)
      HDR_MAGIC: begin
        if (b == CH_P) phase = HDR_GOT_P;
        else if (!blank_char(b)) flag_error(ERR_BAD_MAGIC);
      end
      HDR_GOT_P: begin
        if (b == CH_FOUR) phase = HDR_AFTER_MAGIC;
        else flag_error(ERR_BAD_MAGIC);
      end
      HDR_AFTER_MAGIC: begin
        if (b == CH_NEWLINE) phase = HDR_COMMENT_CHECK;
        else flag_error(blank_char(b) ? ERR_BAD_SEP : ERR_BAD_MAGIC);
      end
      HDR_COMMENT_CHECK: begin
        // Anything but a hash already belongs to the width field.
        if (b == CH_HASH) begin
          phase = HDR_IN_COMMENT;
        end else begin
          phase = HDR_WIDTH_LEAD;
          start_number(b, HDR_WIDTH_DIGITS);
        end
      end
      HDR_IN_COMMENT: begin
        if (b == CH_NEWLINE) phase = HDR_WIDTH_LEAD;
      end
      HDR_WIDTH_LEAD: start_number(b, HDR_WIDTH_DIGITS);
      HDR_HEIGHT_LEAD: start_number(b, HDR_HEIGHT_DIGITS);
      HDR_WIDTH_DIGITS: begin
        if (digit_char(b)) begin
          add_digit(b);
        end else if (b != CH_SPACE) begin
          flag_error(ERR_BAD_SEP);
        end else if (acc == 0 || acc > MAX_DIM) begin
          flag_error(ERR_BAD_DIM);
        end else begin
          img_w = acc;
          acc = '0;
          phase = HDR_HEIGHT_LEAD;
        end
      end
      HDR_HEIGHT_DIGITS: begin
        if (digit_char(b)) begin
          add_digit(b);
        end else if (b != CH_NEWLINE) begin
          flag_error(ERR_BAD_SEP);
        end else if (acc == 0 || acc > MAX_DIM) begin
          flag_error(ERR_BAD_DIM);
        end else begin
          img_h = acc;
          acc = '0;
          row_idx = '0;
          byte_idx = '0;
          phase = HDR_RASTER;
        end
      end
      HDR_RASTER: begin
        for (int i = 0; i < 8; i++) begin
          col = byte_idx * 8 + i;
          if (col < img_w) begin
            px.kind  = KIND_PIXEL;
            px.value = b[7 - i] ? PIX_SET : PIX_CLEAR;
            px.row   = row_idx[11:0];
            px.col   = col[11:0];
            px.last  = (row_idx + 1 == img_h) && (col + 1 == img_w);
            px.code  = ERR_NONE;
            fresh_beats = {fresh_beats, px};
          end
        end
        byte_idx++;
        if (byte_idx >= (img_w + 7) / 8) begin
          byte_idx = '0;
          row_idx++;
          if (row_idx >= img_h) phase = HDR_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic in_beat_t pred_row(logic [7:0] data, logic sof);
    in_beat_t r;
    r = '0;
    r.data = data;
    r.sof = sof;
    return r;
  endfunction

  function automatic in_beat_t quiet_row(logic [7:0] data, logic sof);
    in_beat_t r;
    r = pred_row(data, sof);
    r.hand_checked = 1'b1;
    return r;
  endfunction

  function automatic in_beat_t error_row(logic [7:0] data, logic sof, logic [2:0] code);
    in_beat_t r;
    r = quiet_row(data, sof);
    r.has_beat = 1'b1;
    r.beat.kind = KIND_ERROR;
    r.beat.code = code;
    return r;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_NEWLINE;
      2: return 8'h0B;
      3: return 8'h0C;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic void put_byte(logic [7:0] v);
    file_bytes = {file_bytes, v};
  endfunction

  function automatic void put_number(int v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 5) == 0) put_byte(CH_ZERO);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // Offers one beat, opening a random gap first when the current burst is used up.
  task automatic send_beat(input in_beat_t it);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom_range(0, 255));
      s_tuser <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
    end
    cur_item = it;
    s_tvalid <= 1'b1;
    s_tdata <= it.data;
    s_tuser <= it.sof;
    burst_left--;
    items_sent++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : compare_beats
    out_beat_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        fresh_beats.delete();
        decode_byte(cur_item.data, cur_item.sof);
        if (!cur_item.hand_checked) begin
          expected_beats = {expected_beats, fresh_beats};
        end else if (cur_item.has_beat) begin
          expected_beats = {expected_beats, cur_item.beat};
        end
      end
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          $error("output beat arrived with no result expected");
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", want.kind, m_tuser);
          check_field("pixel_value", want.value, m_tdata[7:0]);
          check_field("pixel_row", want.row, m_tdata[19:8]);
          check_field("pixel_col", want.col, m_tdata[31:20]);
          check_field("error_code", want.code, m_tdata[34:32]);
          check_field("tdata_pad", 0, m_tdata[OUT_DATA_W-1:35]);
          check_field("last_pixel", want.last, m_tlast);
        end
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int cyc;
    cyc = 0;
    while (rst) @(negedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(16, 120)) begin
        if (hold_req && !hold_done) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        cyc++;
        case (mode)
          RX_OPEN:          m_tready <= 1'b1;
          RX_COIN:          m_tready <= 1'($urandom_range(0, 1));
          RX_THREE_OF_FOUR: m_tready <= (cyc % 4) != 3;
          default:          m_tready <= (cyc % 5) == 0;
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    in_beat_t   directed[$];
    in_beat_t   item;
    file_flaw_t flaw;
    int         w, h, n_raster;
    logic [7:0] b;
    logic       stop;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Straight after reset the block parses without a start flag.
    directed = {directed, error_row("Q", 1'b0, ERR_BAD_MAGIC)};
    directed = {directed, quiet_row(CH_P, 1'b0)};
    directed = {directed, pred_row(CH_SPACE, 1'b1)};
    directed = {directed, pred_row(CH_P, 1'b0)};
    directed = {directed, pred_row(CH_FOUR, 1'b0)};
    directed = {directed, pred_row(CH_NEWLINE, 1'b0)};
    directed = {directed, pred_row(CH_HASH, 1'b0)};
    directed = {directed, quiet_row(8'hFF, 1'b0)};
    directed = {directed, pred_row(CH_NEWLINE, 1'b0)};
    directed = {directed, pred_row(CH_TAB, 1'b0)};
    directed = {directed, pred_row("1", 1'b0)};
    directed = {directed, pred_row(CH_SPACE, 1'b0)};
    directed = {directed, pred_row("1", 1'b0)};
    directed = {directed, pred_row(CH_NEWLINE, 1'b0)};
    item = quiet_row(8'h80, 1'b0);
    item.has_beat = 1'b1;
    item.beat = '{KIND_PIXEL, PIX_SET, 12'd0, 12'd0, 1'b1, ERR_NONE};
    directed = {directed, item};
    directed = {directed, quiet_row(8'h7F, 1'b0)};
    directed = {directed, pred_row(CH_P, 1'b1)};
    directed = {directed, pred_row(CH_FOUR, 1'b0)};
    directed = {directed, error_row(CH_SPACE, 1'b0, ERR_BAD_SEP)};
    directed = {directed, pred_row(CH_P, 1'b1)};
    directed = {directed, pred_row(CH_FOUR, 1'b0)};
    directed = {directed, pred_row(CH_NEWLINE, 1'b0)};
    directed = {directed, pred_row(CH_ZERO, 1'b0)};
    directed = {directed, error_row(CH_SPACE, 1'b0, ERR_BAD_DIM)};
    directed = {directed, error_row(CH_HASH, 1'b1, ERR_BAD_MAGIC)};
    directed = {directed, pred_row(CH_P, 1'b1)};
    directed = {directed, error_row("3", 1'b0, ERR_BAD_MAGIC)};

    foreach (directed[i]) send_beat(directed[i]);
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    @(negedge clk);

    // The receiver now holds off while the random files keep coming.
    hold_req = 1'b1;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      file_bytes.delete();
      flaw = ($urandom_range(0, 9) < 6) ? FILE_CLEAN : file_flaw_t'($urandom_range(1, 10));
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 3);
      if (flaw == FILE_MAX_TRUNCATED) begin
        w = MAX_DIM;
        h = MAX_DIM;
      end
      stop = 1'b0;

      if (flaw == FILE_NOISE) begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
        stop = 1'b1;
      end else begin
        repeat ($urandom_range(0, 2)) put_byte(pick_blank());
        if (flaw == FILE_BAD_MAGIC) begin
          if ($urandom_range(0, 1)) begin
            put_byte(CH_P);
            do b = 8'($urandom_range(0, 255)); while (b == CH_FOUR);
          end else begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_P || blank_char(b));
          end
          put_byte(b);
          stop = 1'b1;
        end else begin
          put_byte(CH_P);
          put_byte(CH_FOUR);
          if (flaw == FILE_BAD_AFTER_MAGIC) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
            put_byte(b);
            stop = 1'b1;
          end else begin
            put_byte(CH_NEWLINE);
          end
        end
      end

      if (!stop && (flaw == FILE_SECOND_COMMENT || $urandom_range(0, 1))) begin
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 5)) begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_NEWLINE);
          put_byte(b);
        end
        put_byte(CH_NEWLINE);
        if (flaw == FILE_SECOND_COMMENT) begin
          put_byte(CH_HASH);
          stop = 1'b1;
        end
      end

      if (!stop) begin
        repeat ($urandom_range(0, 1)) put_byte(pick_blank());
        if (flaw == FILE_BAD_WIDTH_START) begin
          do b = 8'($urandom_range(0, 255)); while (digit_char(b) || blank_char(b));
          put_byte(b);
          stop = 1'b1;
        end else if (flaw == FILE_BAD_WIDTH_DIM) begin
          put_number($urandom_range(0, 1) ? 0 : $urandom_range(MAX_DIM + 1, 9999999));
          put_byte(CH_SPACE);
          stop = 1'b1;
        end else begin
          put_number(w);
          if (flaw == FILE_BAD_WIDTH_END) begin
            do b = 8'($urandom_range(0, 255)); while (digit_char(b) || b == CH_SPACE);
            put_byte(b);
            stop = 1'b1;
          end else begin
            put_byte(CH_SPACE);
          end
        end
      end

      if (!stop) begin
        repeat ($urandom_range(0, 1)) put_byte(pick_blank());
        if (flaw == FILE_BAD_HEIGHT_DIM) begin
          put_number($urandom_range(0, 1) ? 0 : $urandom_range(MAX_DIM + 1, 9999999));
          put_byte(CH_NEWLINE);
          stop = 1'b1;
        end else begin
          put_number(h);
          if (flaw == FILE_BAD_HEIGHT_END) begin
            do b = 8'($urandom_range(0, 255)); while (digit_char(b) || b == CH_NEWLINE);
            put_byte(b);
            stop = 1'b1;
          end else begin
            put_byte(CH_NEWLINE);
          end
        end
      end

      // The largest image is only started, never finished.
      if (!stop) begin
        n_raster = (flaw == FILE_MAX_TRUNCATED) ? 3 : h * ((w + 7) / 8);
        if ($urandom_range(0, 7) == 0) n_raster = $urandom_range(0, n_raster - 1);
        repeat (n_raster) put_byte(8'($urandom_range(0, 255)));
      end
      if (stop || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
      end

      foreach (file_bytes[i]) begin
        send_beat(pred_row(file_bytes[i],
                           (i == 0) && (flaw != FILE_NOISE || $urandom_range(0, 1))));
      end
    end

    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
